// ----- hdl/dyp_pkg.sv -----
// Shared types, constants and the arctangent table for the direction to yaw/pitch core.
// Used by dyp_sqrt_cell, dyp_cordic_cell and direction_to_yaw_pitch_core.
package dyp_pkg;

    localparam int ITERATIONS_DEF = 24;
    localparam int SQRT_STEPS     = 32;
    localparam int CW             = 51;
    localparam int AW             = 26;

    localparam logic signed [AW-1:0] ANG_90  = 26'sd5898240;
    localparam logic [AW-1:0]        ANG_360 = 26'd23592960;

    localparam logic [1:0] QUAD_0   = 2'd0;
    localparam logic [1:0] QUAD_90  = 2'd1;
    localparam logic [1:0] QUAD_180 = 2'd2;
    localparam logic [1:0] QUAD_270 = 2'd3;

    typedef struct packed {
        logic                 deg;
        logic                 zneg;
        logic                 zzero;
        logic [1:0]           quad;
        logic [31:0]          az;
        logic [63:0]          n;
        logic [63:0]          res;
        logic [63:0]          sq;
        logic signed [CW-1:0] ya;
        logic signed [CW-1:0] yb;
        logic signed [AW-1:0] yz;
        logic signed [CW-1:0] pa;
        logic signed [CW-1:0] pb;
        logic signed [AW-1:0] pz;
    } t_data;

    function automatic logic signed [AW-1:0] atan_q16(input logic [4:0] idx);
        logic signed [AW-1:0] v;
        case (idx)
            5'd0:  v = 26'sd2949120;
            5'd1:  v = 26'sd1740967;
            5'd2:  v = 26'sd919879;
            5'd3:  v = 26'sd466945;
            5'd4:  v = 26'sd234379;
            5'd5:  v = 26'sd117304;
            5'd6:  v = 26'sd58666;
            5'd7:  v = 26'sd29335;
            5'd8:  v = 26'sd14668;
            5'd9:  v = 26'sd7334;
            5'd10: v = 26'sd3667;
            5'd11: v = 26'sd1833;
            5'd12: v = 26'sd917;
            5'd13: v = 26'sd458;
            5'd14: v = 26'sd229;
            5'd15: v = 26'sd115;
            5'd16: v = 26'sd57;
            5'd17: v = 26'sd29;
            5'd18: v = 26'sd14;
            5'd19: v = 26'sd7;
            5'd20: v = 26'sd4;
            5'd21: v = 26'sd2;
            5'd22: v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/dyp_sqrt_cell.sv -----
// One digit step of the integer square root, registered.
// Depends on dyp_pkg.
module dyp_sqrt_cell
    import dyp_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_data i_d,
    output logic  o_vld,
    output t_data o_d
);

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic        r_vld;
    t_data       r_d;
    t_data       n_d;
    logic [63:0] trial;

    always_comb begin
        n_d   = i_d;
        trial = i_d.res + BIT;
        if (i_d.n >= trial) begin
            n_d.n   = i_d.n - trial;
            n_d.res = (i_d.res >> 1) + BIT;
        end else begin
            n_d.res = i_d.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

// ----- hdl/dyp_cordic_cell.sv -----
// One vectoring rotation for both the yaw and the pitch pair, registered.
// Depends on dyp_pkg.
module dyp_cordic_cell
    import dyp_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_data i_d,
    output logic  o_vld,
    output t_data o_d
);

    localparam logic signed [AW-1:0] ANG = atan_q16(5'(STEP));

    logic  r_vld;
    t_data r_d;
    t_data n_d;

    always_comb begin
        n_d = i_d;
        if (!i_d.yb[CW-1]) begin
            n_d.ya = i_d.ya + (i_d.yb >>> STEP);
            n_d.yb = i_d.yb - (i_d.ya >>> STEP);
            n_d.yz = i_d.yz + ANG;
        end else begin
            n_d.ya = i_d.ya - (i_d.yb >>> STEP);
            n_d.yb = i_d.yb + (i_d.ya >>> STEP);
            n_d.yz = i_d.yz - ANG;
        end
        if (!i_d.pb[CW-1]) begin
            n_d.pa = i_d.pa + (i_d.pb >>> STEP);
            n_d.pb = i_d.pb - (i_d.pa >>> STEP);
            n_d.pz = i_d.pz + ANG;
        end else begin
            n_d.pa = i_d.pa - (i_d.pb >>> STEP);
            n_d.pb = i_d.pb + (i_d.pa >>> STEP);
            n_d.pz = i_d.pz - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_vld = r_vld;
    assign o_d   = r_d;

endmodule

// ----- hdl/direction_to_yaw_pitch_core.sv -----
// Top level of the direction to yaw/pitch converter.
// Depends on dyp_pkg, dyp_sqrt_cell and dyp_cordic_cell.
//
// The core accepts one vector per cycle while it is not stalled and returns one result per vector, in order.
// The pipeline holds ITERATIONS + 36 register stages: three front stages (quadrant fold,
// squares, sum), thirty-two square root cells, one CORDIC cell per iteration and the
// output register, with the quadrant offset and clamping done in logic ahead of the output
// register. The whole pipeline advances whenever the output register is empty or its
// result is being taken, so throughput is one transfer per cycle without stalls.
module direction_to_yaw_pitch_core
    import dyp_pkg::*;
#(
    parameter int ITERATIONS = ITERATIONS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_x_pos,
    input  logic signed [31:0] i_y_pos,
    input  logic signed [31:0] i_z_pos,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [24:0]        o_yaw_deg,
    output logic signed [23:0] o_pitch_deg,
    output logic               o_degenerate
);

    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    logic        r_v0, r_v1, r_v2;
    t_data       r_d0, r_d1, r_d2;
    t_data       n_d0, n_d1, n_d2;
    logic [31:0] ax, ay, ua, ub;

    always_comb begin
        ax = i_x_pos[31] ? (~i_x_pos + 32'd1) : i_x_pos;
        ay = i_y_pos[31] ? (~i_y_pos + 32'd1) : i_y_pos;
        n_d0       = '0;
        n_d0.deg   = (i_x_pos == '0) && (i_y_pos == '0);
        n_d0.zneg  = i_z_pos[31];
        n_d0.zzero = (i_z_pos == '0);
        n_d0.az    = i_z_pos[31] ? (~i_z_pos + 32'd1) : i_z_pos;
        if (!i_x_pos[31] && i_y_pos[31]) begin
            n_d0.quad = QUAD_0;
        end else if (!i_x_pos[31]) begin
            n_d0.quad = QUAD_90;
        end else if (!i_y_pos[31]) begin
            n_d0.quad = QUAD_180;
        end else begin
            n_d0.quad = QUAD_270;
        end
        if (i_x_pos[31] == i_y_pos[31]) begin
            ua = ax;
            ub = ay;
        end else begin
            ua = ay;
            ub = ax;
        end
        n_d0.ya  = $signed({3'b000, ua, 16'h0000});
        n_d0.yb  = $signed({3'b000, ub, 16'h0000});
        n_d0.n   = {32'd0, ax};
        n_d0.sq  = {32'd0, ay};
    end

    always_comb begin
        n_d1    = r_d0;
        n_d1.n  = r_d0.n[31:0] * r_d0.n[31:0];
        n_d1.sq = r_d0.sq[31:0] * r_d0.sq[31:0];
    end

    always_comb begin
        n_d2     = r_d1;
        n_d2.n   = r_d1.n + r_d1.sq;
        n_d2.res = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d0 <= n_d0;
            r_d1 <= n_d1;
            r_d2 <= n_d2;
        end
    end

    logic  s_vld [SQRT_STEPS+1];
    t_data s_d   [SQRT_STEPS+1];

    assign s_vld[0] = r_v2;
    assign s_d[0]   = r_d2;

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        dyp_sqrt_cell #(.STEP(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (s_vld[k]),
            .i_d     (s_d[k]),
            .o_vld   (s_vld[k+1]),
            .o_d     (s_d[k+1])
        );
    end

    logic  c_vld [ITERATIONS+1];
    t_data c_d   [ITERATIONS+1];

    always_comb begin
        c_d[0]    = s_d[SQRT_STEPS];
        c_d[0].pa = $signed({3'b000, s_d[SQRT_STEPS].res[31:0], 16'h0000});
        c_d[0].pb = $signed({3'b000, s_d[SQRT_STEPS].az, 16'h0000});
        c_d[0].pz = '0;
    end
    assign c_vld[0] = s_vld[SQRT_STEPS];

    for (genvar k = 0; k < ITERATIONS; k++) begin : g_cordic
        dyp_cordic_cell #(.STEP(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (c_vld[k]),
            .i_d     (c_d[k]),
            .o_vld   (c_vld[k+1]),
            .o_d     (c_d[k+1])
        );
    end

    t_data                c_last;
    logic signed [AW-1:0] yc, pc;
    logic [AW-1:0]        ysum, yoff, yfin;
    logic [24:0]          n_yaw;
    logic signed [23:0]   n_pitch;

    assign c_last = c_d[ITERATIONS];

    always_comb begin
        if (c_last.yz < 0) begin
            yc = '0;
        end else if (c_last.yz > ANG_90) begin
            yc = ANG_90;
        end else begin
            yc = c_last.yz;
        end
        if (c_last.pz < 0) begin
            pc = '0;
        end else if (c_last.pz > ANG_90) begin
            pc = ANG_90;
        end else begin
            pc = c_last.pz;
        end
        case (c_last.quad)
            QUAD_0:   yoff = '0;
            QUAD_90:  yoff = AW'(ANG_90);
            QUAD_180: yoff = AW'(2 * ANG_90);
            QUAD_270: yoff = AW'(3 * ANG_90);
            default:  yoff = '0;
        endcase
        ysum = AW'(yc) + yoff;
        yfin = (ysum >= ANG_360) ? (ysum - ANG_360) : ysum;
        if (c_last.deg) begin
            n_yaw = '0;
            if (c_last.zzero) begin
                n_pitch = '0;
            end else if (c_last.zneg) begin
                n_pitch = -24'(ANG_90);
            end else begin
                n_pitch = 24'(ANG_90);
            end
        end else begin
            n_yaw   = yfin[24:0];
            n_pitch = c_last.zneg ? -24'(pc) : 24'(pc);
        end
    end

    logic               r_ovld;
    logic [24:0]        r_yaw;
    logic signed [23:0] r_pitch;
    logic               r_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= c_vld[ITERATIONS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_yaw   <= n_yaw;
            r_pitch <= n_pitch;
            r_deg   <= c_last.deg;
        end
    end

    assign o_valid      = r_ovld;
    assign o_yaw_deg    = r_yaw;
    assign o_pitch_deg  = r_pitch;
    assign o_degenerate = r_deg;

    a_deg_yaw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_yaw_deg == '0)
        else $error("degenerate result with nonzero yaw");
    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> {1'b0, o_yaw_deg} < ANG_360)
        else $error("yaw out of range");
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_deg <= 24'(ANG_90)) && (o_pitch_deg >= -24'(ANG_90)))
        else $error("pitch out of range");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_v2) && $stable(c_vld[ITERATIONS]))
        else $error("pipeline moved while stalled");

endmodule
